[hdl/rosd_pkg.sv]
`default_nettype none

package rosd_pkg;

	localparam int DEF_MAX_REGIONS = 8;
	localparam int DEF_MAX_COLUMNS = 1024;
	localparam int DEF_MAX_ROWS    = 1024;

	localparam int REG_ADDR_W = 5;
	localparam int HITS_W     = 21;

	localparam logic [HITS_W-1:0] HITS_MAX = {HITS_W{1'b1}};

	localparam logic [7:0] STRAIGHT_ANGLE     = 8'd90;
	localparam logic [7:0] MAX_ANGLE          = 8'd180;
	localparam int         CENTER_MIN_REGIONS = 3;

	typedef enum logic [2:0] {
		REG_REGION_COLUMNS  = 3'd0,
		REG_REGION_COUNT    = 3'd1,
		REG_SCAN_START_ROW  = 3'd2,
		REG_COUNT_THRESHOLD = 3'd3,
		REG_STOP_DISPARITY  = 3'd4,
		REG_SLOW_DISPARITY  = 3'd5,
		REG_TURN_STRENGTH   = 3'd6,
		REG_BASE_SPEED      = 3'd7
	} reg_idx_t;

	typedef enum logic [1:0] {
		MOVE_FORWARD = 2'd0,
		MOVE_SLOW    = 2'd1,
		MOVE_STOP    = 2'd2
	} move_t;

	typedef struct packed {
		logic [10:0]       region_columns;
		logic [3:0]        region_count;
		logic [9:0]        scan_start_row;
		logic [HITS_W-1:0] count_threshold;
		logic [7:0]        stop_disparity;
		logic [7:0]        slow_disparity;
		logic [6:0]        turn_strength;
		logic [7:0]        base_speed;
	} cfg_t;

	localparam cfg_t CFG_RESET = '{
		region_columns:  11'd213,
		region_count:    4'd3,
		scan_start_row:  10'd288,
		count_threshold: 21'd4089,
		stop_disparity:  8'd168,
		slow_disparity:  8'd67,
		turn_strength:   7'd45,
		base_speed:      8'd80
	};

	typedef struct packed {
		logic       left_obs;
		logic       center_obs;
		logic       right_obs;
		logic       three_plus;
		logic [7:0] peak_left;
		logic [7:0] peak_center;
		logic [7:0] peak_right;
	} summary_t;

endpackage

`default_nettype wire

[hdl/region_obstacle_steering_decider.sv]
// Obstacle steering decider for a stereo camera stream.
// Pixels enter in raster order on the pixel channel (pix_valid, pix_stall), one beat per
// pixel carrying the obstacle mask byte, the disparity byte and the line and frame end marks.
// Each frame-end beat produces exactly one result beat on the result channel (res_valid,
// res_stall) with the steering angle, the movement code and the drive speed; other beats
// produce none. A pixel is taken into an input register and updates its region's hit count and
// peak disparity in the next cycle; a frame-end beat also loads the result register as it leaves
// the input register, and it waits there while a held result still occupies the result register.
// Throughput is one pixel per cycle while pix_stall is low. The single result register is the only limit: while a
// result is held by res_stall, ordinary pixels keep flowing, and pix_stall rises only when a
// further frame-end beat would need the occupied result register.
// Configuration registers sit on the APB port; the user is to write them only while the block is idle (not enforced).
// Reset loads the default configuration, clears the region state and empties both
// registers; no clearing pass is needed. After every frame-end beat the per-frame state is
// cleared in the same cycle the result is loaded.
`default_nettype none

module region_obstacle_steering_decider #(
	parameter int MAX_REGIONS = rosd_pkg::DEF_MAX_REGIONS,
	parameter int MAX_COLUMNS = rosd_pkg::DEF_MAX_COLUMNS,
	parameter int MAX_ROWS    = rosd_pkg::DEF_MAX_ROWS
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            psel,
	input  wire logic                            penable,
	input  wire logic                            pwrite,
	input  wire logic [rosd_pkg::REG_ADDR_W-1:0] paddr,
	input  wire logic [31:0]                     pwdata,
	output logic      [31:0]                     prdata,
	output logic                                 pready,
	input  wire logic                            pix_valid,
	output logic                                 pix_stall,
	input  wire logic [7:0]                      obstacle_pixel,
	input  wire logic [7:0]                      disparity_pixel,
	input  wire logic                            line_end,
	input  wire logic                            frame_end,
	output logic                                 res_valid,
	input  wire logic                            res_stall,
	output logic      [7:0]                      steering_angle,
	output logic      [1:0]                      move_code,
	output logic      [7:0]                      drive_speed
);
	import rosd_pkg::*;

	localparam int COL_W    = $clog2(MAX_COLUMNS);
	localparam int ROW_W    = $clog2(MAX_ROWS);
	localparam int REG_W    = $clog2(MAX_REGIONS + 1);
	localparam int IDX_W    = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;
	localparam int CNXT_W   = (COL_W + 1 > 11) ? COL_W + 1 : 11;
	localparam int ROWC_W   = (ROW_W > 10) ? ROW_W : 10;
	localparam int CTR_LANE = (MAX_REGIONS > 1) ? 1 : 0;

	localparam logic [COL_W-1:0] COLUMN_MAX = COL_W'(MAX_COLUMNS - 1);
	localparam logic [ROW_W-1:0] ROW_MAX    = ROW_W'(MAX_ROWS - 1);

	cfg_t     cfg;
	summary_t sum;
	move_t    dec_code;
	logic [7:0] dec_angle;
	logic [7:0] dec_speed;

	logic       valid_s1;
	logic [7:0] obst_s1;
	logic [7:0] disp_s1;
	logic       eol_s1;
	logic       eof_s1;

	logic [ROW_W-1:0] row_q;
	logic [COL_W-1:0] col_q;
	logic [REG_W-1:0] region_q;
	logic [HITS_W-1:0] hits_q [MAX_REGIONS];
	logic [7:0]        peak_q [MAX_REGIONS];

	logic [HITS_W-1:0] hits_nx [MAX_REGIONS];
	logic [7:0]        peak_nx [MAX_REGIONS];
	logic [MAX_REGIONS-1:0] obs;

	logic [REG_W-1:0]  n_act;
	logic [IDX_W-1:0]  idx_last;
	logic [CNXT_W-1:0] col_next;
	logic              in_rows;
	logic              count_en;
	logic              adv;
	logic              step;
	logic              pix_accept;

	logic [7:0] res_angle_q;
	logic [1:0] res_code_q;
	logic [7:0] res_speed_q;
	logic       res_valid_q;

	rosd_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	assign adv        = !(eof_s1 && res_valid_q && res_stall);
	assign pix_stall  = valid_s1 && !adv;
	assign pix_accept = pix_valid && !pix_stall;
	assign step       = valid_s1 && adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!pix_stall) begin
			valid_s1 <= pix_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (pix_accept) begin
			obst_s1 <= obstacle_pixel;
			disp_s1 <= disparity_pixel;
			eol_s1  <= line_end;
			eof_s1  <= frame_end;
		end
	end

	always_comb begin
		if (cfg.region_count == 4'd0) begin
			n_act = REG_W'(1);
		end else if (32'(cfg.region_count) > MAX_REGIONS) begin
			n_act = REG_W'(MAX_REGIONS);
		end else begin
			n_act = REG_W'(cfg.region_count);
		end
		idx_last = IDX_W'(n_act - REG_W'(1));
		col_next = CNXT_W'(col_q) + CNXT_W'(1);
		in_rows  = ROWC_W'(row_q) >= ROWC_W'(cfg.scan_start_row);
		count_en = in_rows && (region_q < n_act) && (obst_s1 != 8'd0);
	end

	always_comb begin
		for (int i = 0; i < MAX_REGIONS; i++) begin
			hits_nx[i] = hits_q[i];
			peak_nx[i] = peak_q[i];
			if (count_en && (region_q == REG_W'(i))) begin
				if (hits_q[i] != HITS_MAX) begin
					hits_nx[i] = hits_q[i] + HITS_W'(1);
				end
				if (disp_s1 > peak_q[i]) begin
					peak_nx[i] = disp_s1;
				end
			end
			obs[i] = (hits_nx[i] > cfg.count_threshold) || (peak_nx[i] > cfg.stop_disparity);
		end
	end

	always_comb begin
		sum.three_plus  = 32'(n_act) >= CENTER_MIN_REGIONS;
		sum.left_obs    = obs[0];
		sum.center_obs  = sum.three_plus && obs[CTR_LANE];
		sum.right_obs   = obs[idx_last];
		sum.peak_left   = peak_nx[0];
		sum.peak_center = peak_nx[CTR_LANE];
		sum.peak_right  = peak_nx[idx_last];
	end

	rosd_decide u_decide (
		.cfg   (cfg),
		.sum   (sum),
		.angle (dec_angle),
		.code  (dec_code),
		.speed (dec_speed)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q    <= '0;
			col_q    <= '0;
			region_q <= '0;
			for (int i = 0; i < MAX_REGIONS; i++) begin
				hits_q[i] <= '0;
				peak_q[i] <= '0;
			end
		end else if (step) begin
			if (eof_s1) begin
				row_q    <= '0;
				col_q    <= '0;
				region_q <= '0;
				for (int i = 0; i < MAX_REGIONS; i++) begin
					hits_q[i] <= '0;
					peak_q[i] <= '0;
				end
			end else begin
				for (int i = 0; i < MAX_REGIONS; i++) begin
					hits_q[i] <= hits_nx[i];
					peak_q[i] <= peak_nx[i];
				end
				if (eol_s1) begin
					col_q    <= '0;
					region_q <= '0;
					if (row_q != ROW_MAX) begin
						row_q <= row_q + ROW_W'(1);
					end
				end else if (col_next >= CNXT_W'(cfg.region_columns)) begin
					col_q <= '0;
					if (region_q < n_act) begin
						region_q <= region_q + REG_W'(1);
					end
				end else if (col_next > CNXT_W'(COLUMN_MAX)) begin
					col_q <= COLUMN_MAX;
				end else begin
					col_q <= col_next[COL_W-1:0];
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (step && eof_s1) begin
			res_valid_q <= 1'b1;
		end else if (!res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step && eof_s1) begin
			res_angle_q <= dec_angle;
			res_code_q  <= dec_code;
			res_speed_q <= dec_speed;
		end
	end

	assign res_valid      = res_valid_q;
	assign steering_angle = res_angle_q;
	assign move_code      = res_code_q;
	assign drive_speed    = res_speed_q;

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		pix_stall |-> (valid_s1 && eof_s1 && res_valid_q && res_stall))
		else $error("Pixel channel stalled without a blocked frame-end beat.");

	a_frame_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(step && eof_s1) |=> (row_q == '0 && col_q == '0 && region_q == '0))
		else $error("Frame state not cleared after a frame-end beat.");

	a_stop_result: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid_q && res_code_q == MOVE_STOP) |->
			(res_speed_q == 8'd0 && res_angle_q == STRAIGHT_ANGLE))
		else $error("Stop result with nonzero speed or turned angle.");

	a_region_bound: assert property (@(posedge clk) disable iff (!arst_n)
		$changed(region_q) && region_q != '0 |-> region_q == $past(region_q) + REG_W'(1))
		else $error("Region position skipped a region.");

endmodule

`default_nettype wire

[hdl/rosd_cfg.sv]
`default_nettype none

module rosd_cfg (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            psel,
	input  wire logic                            penable,
	input  wire logic                            pwrite,
	input  wire logic [rosd_pkg::REG_ADDR_W-1:0] paddr,
	input  wire logic [31:0]                     pwdata,
	output logic      [31:0]                     prdata,
	output logic                                 pready,
	output rosd_pkg::cfg_t                       cfg
);
	import rosd_pkg::*;

	cfg_t     cfg_q;
	reg_idx_t idx;
	logic     wr_en;

	assign idx    = reg_idx_t'(paddr[REG_ADDR_W-1:2]);
	assign wr_en  = psel && penable && pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= CFG_RESET;
		end else if (wr_en) begin
			unique case (idx)
				REG_REGION_COLUMNS:  cfg_q.region_columns  <= pwdata[10:0];
				REG_REGION_COUNT:    cfg_q.region_count    <= pwdata[3:0];
				REG_SCAN_START_ROW:  cfg_q.scan_start_row  <= pwdata[9:0];
				REG_COUNT_THRESHOLD: cfg_q.count_threshold <= pwdata[HITS_W-1:0];
				REG_STOP_DISPARITY:  cfg_q.stop_disparity  <= pwdata[7:0];
				REG_SLOW_DISPARITY:  cfg_q.slow_disparity  <= pwdata[7:0];
				REG_TURN_STRENGTH:   cfg_q.turn_strength   <= pwdata[6:0];
				REG_BASE_SPEED:      cfg_q.base_speed      <= pwdata[7:0];
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			REG_REGION_COLUMNS:  prdata = 32'(cfg_q.region_columns);
			REG_REGION_COUNT:    prdata = 32'(cfg_q.region_count);
			REG_SCAN_START_ROW:  prdata = 32'(cfg_q.scan_start_row);
			REG_COUNT_THRESHOLD: prdata = 32'(cfg_q.count_threshold);
			REG_STOP_DISPARITY:  prdata = 32'(cfg_q.stop_disparity);
			REG_SLOW_DISPARITY:  prdata = 32'(cfg_q.slow_disparity);
			REG_TURN_STRENGTH:   prdata = 32'(cfg_q.turn_strength);
			REG_BASE_SPEED:      prdata = 32'(cfg_q.base_speed);
		endcase
	end

endmodule

`default_nettype wire

[hdl/rosd_decide.sv]
`default_nettype none

module rosd_decide (
	input  wire rosd_pkg::cfg_t     cfg,
	input  wire rosd_pkg::summary_t sum,
	output logic [7:0]              angle,
	output rosd_pkg::move_t         code,
	output logic [7:0]              speed
);
	import rosd_pkg::*;

	logic [7:0] left_angle;
	logic [7:0] right_sum;
	logic [7:0] right_angle;

	always_comb begin
		left_angle = (cfg.turn_strength > 7'(STRAIGHT_ANGLE)) ? 8'd0
			: STRAIGHT_ANGLE - {1'b0, cfg.turn_strength};
		right_sum   = STRAIGHT_ANGLE + {1'b0, cfg.turn_strength};
		right_angle = (right_sum > MAX_ANGLE) ? MAX_ANGLE : right_sum;
	end

	always_comb begin
		angle = STRAIGHT_ANGLE;
		code  = MOVE_FORWARD;
		speed = cfg.base_speed;
		priority if (!sum.left_obs && !sum.center_obs && !sum.right_obs) begin
			angle = STRAIGHT_ANGLE;
		end else if (!sum.center_obs) begin
			if (sum.three_plus && (sum.peak_center > cfg.slow_disparity)) begin
				code  = MOVE_SLOW;
				speed = {1'b0, cfg.base_speed[7:1]};
			end
		end else if (!sum.left_obs && !sum.right_obs) begin
			angle = (sum.peak_left <= sum.peak_right) ? left_angle : right_angle;
		end else if (!sum.left_obs) begin
			angle = left_angle;
		end else if (!sum.right_obs) begin
			angle = right_angle;
		end else begin
			code  = MOVE_STOP;
			speed = 8'd0;
		end
	end

endmodule

`default_nettype wire
